### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, held off while rst_ni is low.
`define SSG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ssg assertion failed");

// Next-cycle implication, sampled on clk_i, held off while rst_ni is low.
`define SSG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ssg assertion failed");

`endif

### hw/rtl/ssg_pkg.sv
package ssg_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 11;

  localparam logic [CAP_W-1:0] CAP_RESET     = 11'd1024;
  localparam logic [CAP_W-1:0] MIN_FOR_SPANS = 11'd2;
  localparam logic [VAL_W-1:0] GAP_RESET     = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_DONE
  } st_e;

endpackage

### hw/rtl/ssg_ram.sv
module ssg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/sorted_set_min_max_gap.sv
// Sorted value store with running minimum neighbor gap and value range. Raise start with
// new_value_i while busy is low; every word gives exactly one result on done_o one cycle
// wide, and the receiver cannot stall it. A word rejected as full is answered on the next
// cycle and busy stays low. An accepted word walks the value RAM downward from the top entry,
// one entry a cycle, moving each larger entry up by one until it finds its slot. busy stays high
// through the scan, through a write of the bottom entry when the word lands there, and through
// a final update state (only that state for an empty store); done_o goes high in the same
// cycle that busy goes low. Values are stored in offset-binary form so unsigned compares give
// signed order and differences are exact.
module sorted_set_min_max_gap
  import ssg_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [VAL_W-1:0] new_value_i,
  input  logic                    cfg_we_i,
  input  logic [CAP_W-1:0]        cfg_wdata_i,
  output logic                    done_o,
  output logic                    add_status_o,
  output logic [CAP_W-1:0]        held_count_o,
  output logic                    spans_valid_o,
  output logic [VAL_W-1:0]        shortest_gap_o,
  output logic [VAL_W-1:0]        longest_gap_o
);

  localparam int unsigned AW   = $clog2(STORE_DEPTH);
  localparam int unsigned CW   = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;

  st_e              st_q, st_d;
  logic [CAP_W-1:0] cap_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [VAL_W-1:0] best_q, best_d;
  logic [VAL_W-1:0] least_q, least_d;
  logic [VAL_W-1:0] greatest_q, greatest_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [VAL_W-1:0] upper_q, upper_d;
  logic [VAL_W-1:0] lower_q, lower_d;
  logic             has_upper_q, has_upper_d;
  logic             has_lower_q, has_lower_d;
  logic [AW-1:0]    cur_q, cur_d;
  logic             status_q, status_d;
  logic             done_q, done_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  logic [VAL_W-1:0] v_in;
  logic [CMPW-1:0]  cnt_ext, cap_ext, depth_ext, lim_ext;
  logic             accept, room, spans_ok;
  logic [VAL_W-1:0] gap_lo, gap_hi, best_mid;

  ssg_ram #(
    .WIDTH(VAL_W),
    .DEPTH(STORE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign v_in      = {~new_value_i[VAL_W-1], new_value_i[VAL_W-2:0]};
  assign cnt_ext   = CMPW'(cnt_q);
  assign cap_ext   = CMPW'(cap_q);
  assign depth_ext = CMPW'(STORE_DEPTH);
  assign lim_ext   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
  assign room      = cnt_ext < lim_ext;
  assign busy      = (st_q != ST_IDLE);
  assign accept    = start && !busy;

  assign gap_lo   = val_q - lower_q;
  assign gap_hi   = upper_q - val_q;
  assign best_mid = (has_lower_q && (gap_lo < best_q)) ? gap_lo : best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CAP_RESET;
      cnt_q    <= '0;
      best_q   <= GAP_RESET;
      status_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      cnt_q    <= cnt_d;
      best_q   <= best_d;
      status_q <= status_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    least_q     <= least_d;
    greatest_q  <= greatest_d;
    val_q       <= val_d;
    upper_q     <= upper_d;
    lower_q     <= lower_d;
    has_upper_q <= has_upper_d;
    has_lower_q <= has_lower_d;
    cur_q       <= cur_d;
  end

  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    best_d      = best_q;
    least_d     = least_q;
    greatest_d  = greatest_q;
    val_d       = val_q;
    upper_d     = upper_q;
    lower_d     = lower_q;
    has_upper_d = has_upper_q;
    has_lower_d = has_lower_q;
    cur_d       = cur_q;
    status_d    = status_q;
    done_d      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = AW'(cur_q + 1'b1);
    ram_wdata   = ram_rdata;
    ram_raddr   = AW'(cnt_q - 1'b1);

    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          if (room) begin
            val_d       = v_in;
            has_upper_d = 1'b0;
            has_lower_d = 1'b0;
            if (cnt_q == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = v_in;
              st_d      = ST_DONE;
            end else begin
              cur_d = AW'(cnt_q - 1'b1);
              st_d  = ST_SCAN;
            end
          end else begin
            status_d = 1'b1;
            done_d   = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        ram_we = 1'b1;
        if (ram_rdata > val_q) begin
          upper_d     = ram_rdata;
          has_upper_d = 1'b1;
          if (cur_q == '0) begin
            st_d = ST_PLACE;
          end else begin
            cur_d     = cur_q - 1'b1;
            ram_raddr = cur_q - 1'b1;
          end
        end else begin
          ram_wdata   = val_q;
          lower_d     = ram_rdata;
          has_lower_d = 1'b1;
          st_d        = ST_DONE;
        end
      end
      ST_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = val_q;
        st_d      = ST_DONE;
      end
      ST_DONE: begin
        best_d = (has_upper_q && (gap_hi < best_mid)) ? gap_hi : best_mid;
        if (cnt_q == '0) begin
          least_d    = val_q;
          greatest_d = val_q;
        end else begin
          if (val_q < least_q) begin
            least_d = val_q;
          end
          if (val_q > greatest_q) begin
            greatest_d = val_q;
          end
        end
        cnt_d    = cnt_q + 1'b1;
        status_d = 1'b0;
        done_d   = 1'b1;
        st_d     = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  assign spans_ok       = cnt_ext >= CMPW'(MIN_FOR_SPANS);
  assign done_o         = done_q;
  assign add_status_o   = status_q;
  assign held_count_o   = cnt_ext[CAP_W-1:0];
  assign spans_valid_o  = spans_ok;
  assign shortest_gap_o = spans_ok ? best_q : '0;
  assign longest_gap_o  = spans_ok ? (greatest_q - least_q) : '0;

endmodule

### hw/rtl/ssg_checker.sv
`include "assert_macros.svh"

module ssg_checker
  import ssg_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic signed [VAL_W-1:0] new_value_i,
  input logic                    cfg_we_i,
  input logic [CAP_W-1:0]        cfg_wdata_i,
  input logic                    done_o,
  input logic                    add_status_o,
  input logic [CAP_W-1:0]        held_count_o,
  input logic                    spans_valid_o,
  input logic [VAL_W-1:0]        shortest_gap_o,
  input logic [VAL_W-1:0]        longest_gap_o
);

  `SSG_ASSERT_NEXT(a_accept_answered, start && !busy, done_o || busy)
  `SSG_ASSERT_NOW(a_busy_after_start, $rose(busy), $past(start))
  `SSG_ASSERT_NOW(a_no_span_zero, done_o && !spans_valid_o, shortest_gap_o == '0 && longest_gap_o == '0)
  `SSG_ASSERT_NOW(a_gap_within_range, done_o && spans_valid_o, shortest_gap_o <= longest_gap_o)
  `SSG_ASSERT_NEXT(a_reject_keeps_count, done_o && add_status_o && !start, !done_o && $stable(held_count_o))

endmodule

bind sorted_set_min_max_gap ssg_checker u_ssg_checker (.*);
